>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the lux calculation block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("invariant check failed");

`endif

>>> rtl/lftcc_pkg.sv
// ----------------------------------------------------------------------------
// Lux calculation package
// Types, coefficients, region codes and the power table of the lux block.
// ----------------------------------------------------------------------------
package lftcc_pkg;

  localparam int unsigned RATIO_FRAC_BITS_DEF = 12;
  localparam int unsigned LUX_FRAC_BITS = 10;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned LUX_W = 21;
  localparam int unsigned ACC_W = 28;
  localparam int unsigned TAB_W = 16;
  localparam int unsigned TAB_DEPTH = 129;
  localparam int unsigned COEF_W = 12;

  localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

  localparam logic [2:0] REG_ZERO = 3'd0;
  localparam logic [2:0] REG_LOW = 3'd1;
  localparam logic [2:0] REG_MID = 3'd2;
  localparam logic [2:0] REG_HIGH = 3'd3;
  localparam logic [2:0] REG_TOP = 3'd4;
  localparam logic [2:0] REG_OVER = 3'd5;

  localparam logic [COEF_W-1:0] C1_B = 12'd1992;
  localparam logic [COEF_W-1:0] C1_P = 12'd4063;
  localparam logic [COEF_W-1:0] C2_B = 12'd1468;
  localparam logic [COEF_W-1:0] C2_I = 12'd2032;
  localparam logic [COEF_W-1:0] C3_B = 12'd839;
  localparam logic [COEF_W-1:0] C3_I = 12'd1003;
  localparam logic [COEF_W-1:0] C4_B = 12'd96;
  localparam logic [COEF_W-1:0] C4_I = 12'd79;

  typedef struct packed {
    logic [CNT_W-1:0] broadband_count;
    logic [CNT_W-1:0] infrared_count;
  } lftcc_in_t;

  typedef struct packed {
    logic [LUX_W-1:0] lux_q10;
    logic [2:0]       formula_region;
  } lftcc_out_t;

  typedef struct packed {
    logic             vld;
    logic [2:0]       region;
    logic [CNT_W-1:0] broad;
    logic [CNT_W-1:0] ir;
  } lftcc_ctx_t;

  typedef logic [TAB_W-1:0] lftcc_tab_t [TAB_DEPTH];

  // Nearest integer to 65536 * (k/256)^1.4, found by a binary search on
  // (2t-1)^5 <= 2^29 * k^7.
  function automatic logic [TAB_W-1:0] pow_entry(input int unsigned k);
    logic [95:0] lim;
    logic [95:0] u;
    logic [95:0] u5;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lim = 96'd1;
    lo = 1;
    hi = 32767;
    if (k == 0) begin
      return '0;
    end
    for (int i = 0; i < 7; i++) begin
      lim = lim * 96'(k);
    end
    lim = lim << 29;
    for (int it = 0; it < 16; it++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        u = 96'(2 * mid - 1);
        u5 = u * u * u * u * u;
        if (u5 <= lim) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return TAB_W'(lo);
  endfunction

  function automatic lftcc_tab_t build_pow_table();
    lftcc_tab_t tab;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      tab[k] = pow_entry(k);
    end
    return tab;
  endfunction

  localparam lftcc_tab_t POW_TABLE = build_pow_table();

endpackage

>>> rtl/lftcc_classify.sv
// ----------------------------------------------------------------------------
// Region classifier
// Picks the formula region by exact cross-multiplied compares and loads the
// first remainder of the ratio divider.
// ----------------------------------------------------------------------------
module lftcc_classify (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  input  lftcc_pkg::lftcc_in_t      item_i,
  output lftcc_pkg::lftcc_ctx_t     ctx_o,
  output logic [lftcc_pkg::CNT_W-1:0] rem_o
);

  lftcc_pkg::lftcc_ctx_t ctx_d, ctx_q;
  logic [lftcc_pkg::CNT_W-1:0] rem_d, rem_q;
  logic [23:0] b_w, i_w;

  assign b_w = 24'(item_i.broadband_count);
  assign i_w = 24'(item_i.infrared_count);

  always_comb begin
    ctx_d.vld = vld_i;
    ctx_d.broad = item_i.broadband_count;
    ctx_d.ir = item_i.infrared_count;
    if (b_w == 24'd0) begin
      ctx_d.region = lftcc_pkg::REG_ZERO;
    end else if ((i_w << 1) <= b_w) begin
      ctx_d.region = lftcc_pkg::REG_LOW;
    end else if (i_w * 24'd100 <= b_w * 24'd61) begin
      ctx_d.region = lftcc_pkg::REG_MID;
    end else if (i_w * 24'd5 <= b_w * 24'd4) begin
      ctx_d.region = lftcc_pkg::REG_HIGH;
    end else if (i_w * 24'd10 <= b_w * 24'd13) begin
      ctx_d.region = lftcc_pkg::REG_TOP;
    end else begin
      ctx_d.region = lftcc_pkg::REG_OVER;
    end
    rem_d = (ctx_d.region == lftcc_pkg::REG_LOW) ? item_i.infrared_count : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= '0;
    end else begin
      ctx_q <= ctx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign ctx_o = ctx_q;
  assign rem_o = rem_q;

endmodule

>>> rtl/lftcc_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring-division step: settles one quotient bit of the ratio and
// hands remainder, partial quotient and beat context to the next cell.
// ----------------------------------------------------------------------------
module lftcc_div_cell #(
  parameter int unsigned QW  = lftcc_pkg::RATIO_FRAC_BITS_DEF,
  parameter int unsigned BIT = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lftcc_pkg::lftcc_ctx_t       ctx_i,
  input  logic [lftcc_pkg::CNT_W-1:0] rem_i,
  input  logic [QW-1:0]               quo_i,
  output lftcc_pkg::lftcc_ctx_t       ctx_o,
  output logic [lftcc_pkg::CNT_W-1:0] rem_o,
  output logic [QW-1:0]               quo_o
);

  localparam int unsigned CW = lftcc_pkg::CNT_W;

  lftcc_pkg::lftcc_ctx_t ctx_q;
  logic [CW:0]   shifted, trial;
  logic          fits;
  logic [CW-1:0] rem_d, rem_q;
  logic [QW-1:0] quo_d, quo_q;

  always_comb begin
    shifted = {rem_i, 1'b0};
    trial = shifted - {1'b0, ctx_i.broad};
    fits = shifted >= {1'b0, ctx_i.broad};
    rem_d = fits ? trial[CW-1:0] : shifted[CW-1:0];
    quo_d = quo_i;
    quo_d[BIT] = fits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= '0;
    end else begin
      ctx_q <= ctx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign ctx_o = ctx_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

>>> rtl/lftcc_interp.sv
// ----------------------------------------------------------------------------
// Power term interpolator
// Looks up ratio^1.4 in the Q16 table and interpolates linearly on the low
// ratio bits, over two register stages.
// ----------------------------------------------------------------------------
module lftcc_interp #(
  parameter int unsigned RATIO_FRAC_BITS = lftcc_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lftcc_pkg::lftcc_ctx_t       ctx_i,
  input  logic [RATIO_FRAC_BITS-1:0]  ratio_i,
  output lftcc_pkg::lftcc_ctx_t       ctx_o,
  output logic [lftcc_pkg::TAB_W-1:0] pow_o
);

  localparam int unsigned S  = RATIO_FRAC_BITS - 8;
  localparam int unsigned FW = (S == 0) ? 1 : S;
  localparam int unsigned TW = lftcc_pkg::TAB_W;
  localparam int unsigned PW = TW + FW;

  logic [7:0]    k, k1;
  logic [FW-1:0] frac_d, frac_q;
  logic [TW-1:0] t0_d, t0_q, t1, dlt_d, dlt_q;
  logic [PW-1:0] prod;
  logic [TW-1:0] pow_d, pow_q;
  lftcc_pkg::lftcc_ctx_t ctx_a_q, ctx_b_q;

  assign k = ratio_i[RATIO_FRAC_BITS-1:S];
  assign k1 = k + 8'd1;

  if (S == 0) begin : g_nofrac
    assign frac_d = '0;
  end else begin : g_frac
    assign frac_d = ratio_i[FW-1:0];
  end

  always_comb begin
    if (k[7]) begin
      t0_d = lftcc_pkg::POW_TABLE[lftcc_pkg::TAB_DEPTH-1];
      t1 = t0_d;
    end else begin
      t0_d = lftcc_pkg::POW_TABLE[k];
      t1 = lftcc_pkg::POW_TABLE[k1];
    end
    dlt_d = t1 - t0_d;
  end

  always_comb begin
    prod = PW'(dlt_q) * PW'(frac_q);
    pow_d = t0_q + TW'(prod >> S);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_a_q <= '0;
      ctx_b_q <= '0;
    end else begin
      ctx_a_q <= ctx_i;
      ctx_b_q <= ctx_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q <= t0_d;
    dlt_q <= dlt_d;
    frac_q <= frac_d;
    pow_q <= pow_d;
  end

  assign ctx_o = ctx_b_q;
  assign pow_o = pow_q;

endmodule

>>> rtl/lftcc_formula.sv
// ----------------------------------------------------------------------------
// Formula evaluator
// Forms the region's positive and negative terms, then rounds, clamps and
// saturates the difference into the output register.
// ----------------------------------------------------------------------------
module lftcc_formula (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lftcc_pkg::lftcc_ctx_t       ctx_i,
  input  logic [lftcc_pkg::TAB_W-1:0] pow_i,
  output lftcc_pkg::lftcc_out_t       result_o,
  output logic                        result_valid_o
);

  localparam int unsigned AW = lftcc_pkg::ACC_W;
  localparam int unsigned SH = 16 - lftcc_pkg::LUX_FRAC_BITS;
  localparam logic [AW:0] HALF = (SH == 0) ? '0 : (AW+1)'(1) << (SH - 1);

  lftcc_pkg::lftcc_ctx_t ctx_c_q, ctx_d_q, ctx_e_q;
  logic [31:0]   bp_d, bp_q;
  logic [43:0]   scaled;
  logic [AW-1:0] pos_d, pos_q, neg_d, neg_q, diff;
  logic [AW:0]   rounded;
  logic [AW:0]   shifted;
  lftcc_pkg::lftcc_out_t res_d, res_q;

  assign bp_d = 32'(ctx_i.broad) * 32'(pow_i);

  always_comb begin
    scaled = 44'(bp_q) * 44'(lftcc_pkg::C1_P) + 44'd32768;
    case (ctx_c_q.region)
      lftcc_pkg::REG_LOW: begin
        pos_d = AW'(ctx_c_q.broad) * AW'(lftcc_pkg::C1_B);
        neg_d = AW'(scaled >> 16);
      end
      lftcc_pkg::REG_MID: begin
        pos_d = AW'(ctx_c_q.broad) * AW'(lftcc_pkg::C2_B);
        neg_d = AW'(ctx_c_q.ir) * AW'(lftcc_pkg::C2_I);
      end
      lftcc_pkg::REG_HIGH: begin
        pos_d = AW'(ctx_c_q.broad) * AW'(lftcc_pkg::C3_B);
        neg_d = AW'(ctx_c_q.ir) * AW'(lftcc_pkg::C3_I);
      end
      lftcc_pkg::REG_TOP: begin
        pos_d = AW'(ctx_c_q.broad) * AW'(lftcc_pkg::C4_B);
        neg_d = AW'(ctx_c_q.ir) * AW'(lftcc_pkg::C4_I);
      end
      default: begin
        pos_d = '0;
        neg_d = '0;
      end
    endcase
  end

  always_comb begin
    diff = pos_q - neg_q;
    rounded = {1'b0, diff} + HALF;
    shifted = rounded >> SH;
    res_d.formula_region = ctx_d_q.region;
    if (pos_q <= neg_q) begin
      res_d.lux_q10 = '0;
    end else if (shifted > (AW+1)'(lftcc_pkg::LUX_MAX)) begin
      res_d.lux_q10 = lftcc_pkg::LUX_MAX;
    end else begin
      res_d.lux_q10 = shifted[lftcc_pkg::LUX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_c_q <= '0;
      ctx_d_q <= '0;
      ctx_e_q <= '0;
    end else begin
      ctx_c_q <= ctx_i;
      ctx_d_q <= ctx_c_q;
      ctx_e_q <= ctx_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q <= bp_d;
    pos_q <= pos_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign result_o = res_q;
  assign result_valid_o = ctx_e_q.vld;

endmodule

>>> rtl/lux_from_two_channel_counts.sv
// ----------------------------------------------------------------------------
// Two-channel lux calculator
// Converts a broadband and infrared count pair into Q10 lux and a region code.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------
//   input   | start && !busy       | item_i   (broadband, infrared)
//   result  | result_valid_o       | result_o (lux_q10, formula_region)
//
// A new beat is taken every cycle; busy never rises.
// A result appears after its beat has passed one divider cell per ratio bit
// plus six arithmetic stages, all registered and none stalled.
// Reset clears the beat context of every stage; the data registers need none.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lux_from_two_channel_counts #(
  parameter int unsigned RATIO_FRAC_BITS = lftcc_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  lftcc_pkg::lftcc_in_t  item_i,
  output lftcc_pkg::lftcc_out_t result_o,
  output logic                  result_valid_o
);

  localparam int unsigned QW  = RATIO_FRAC_BITS;
  localparam int unsigned LAT = RATIO_FRAC_BITS + 6;

  lftcc_pkg::lftcc_ctx_t       ctx_c [QW+1];
  logic [lftcc_pkg::CNT_W-1:0] rem_c [QW+1];
  logic [QW-1:0]               quo_c [QW+1];
  lftcc_pkg::lftcc_ctx_t       ctx_p;
  logic [lftcc_pkg::TAB_W-1:0] pow;
  logic                        dark_region;

  assign busy = 1'b0;
  assign quo_c[0] = '0;

  assign dark_region = (result_o.formula_region == lftcc_pkg::REG_ZERO) ||
                       (result_o.formula_region == lftcc_pkg::REG_OVER);

  lftcc_classify u_classify (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start && !busy),
    .item_i (item_i),
    .ctx_o  (ctx_c[0]),
    .rem_o  (rem_c[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    lftcc_div_cell #(
      .QW  (QW),
      .BIT (QW - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctx_i  (ctx_c[i]),
      .rem_i  (rem_c[i]),
      .quo_i  (quo_c[i]),
      .ctx_o  (ctx_c[i+1]),
      .rem_o  (rem_c[i+1]),
      .quo_o  (quo_c[i+1])
    );
  end

  lftcc_interp #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctx_i   (ctx_c[QW]),
    .ratio_i (quo_c[QW]),
    .ctx_o   (ctx_p),
    .pow_o   (pow)
  );

  lftcc_formula u_formula (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctx_i          (ctx_p),
    .pow_i          (pow),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  `ASSERT_IMPLIES(a_result_follows, clk_i, rst_ni, start && !busy, ##LAT result_valid_o)
  `ASSERT_IMPLIES(a_no_spurious, clk_i, rst_ni, !start, ##LAT !result_valid_o)
  `ASSERT_IMPLIES(a_dark_zero, clk_i, rst_ni, result_valid_o && dark_region, result_o.lux_q10 == '0)

endmodule
